>>> sv/lru_writeback_block_cache_core_macros.svh
// Assertion macros for the cache core
`ifndef LRU_WRITEBACK_BLOCK_CACHE_CORE_MACROS_SVH
`define LRU_WRITEBACK_BLOCK_CACHE_CORE_MACROS_SVH

// same-cycle implication
`define LWBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LWBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lwbc_pkg.sv
package lwbc_pkg;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned SLOT_W      = $clog2(SLOTS);
  localparam int unsigned OFS_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned OFF_W       = 40;
  localparam int unsigned TAG_W       = OFF_W - OFS_W;
  localparam int unsigned FILE_W      = 8;
  localparam int unsigned AGE_W       = 4;
  localparam int unsigned CNT_W       = 5;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_FLUSH = 3'd2;
  localparam logic [2:0] CMD_CLOSE = 3'd3;
  localparam logic [2:0] CMD_TRIM  = 3'd4;

  typedef enum logic [2:0] {
    KIND_HIT  = 3'd0,
    KIND_FILL = 3'd1,
    KIND_WB   = 3'd2,
    KIND_DROP = 3'd3,
    KIND_DONE = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACC_RES,
    ST_ACC_OLD,
    ST_EV_SCAN,
    ST_EV_EMIT,
    ST_FLUSH,
    ST_CLOSE,
    ST_DONE
  } state_e;

endpackage

>>> sv/lwbc_in_if.sv
interface lwbc_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  cmd;
  logic [lwbc_pkg::FILE_W-1:0] file_id;
  logic [lwbc_pkg::OFF_W-1:0]  byte_offset;
  modport source (output valid, cmd, file_id, byte_offset, input ready);
  modport sink   (input valid, cmd, file_id, byte_offset, output ready);
endinterface

>>> sv/lwbc_out_if.sv
interface lwbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  kind;
  logic [lwbc_pkg::FILE_W-1:0] out_file;
  logic [lwbc_pkg::OFF_W-1:0]  block_base;
  logic [3:0]                  slot;
  logic                        last;
  modport source (output valid, kind, out_file, block_base, slot, last, input ready);
  modport sink   (input valid, kind, out_file, block_base, slot, last, output ready);
endinterface

>>> sv/lwbc_cfg_if.sv
interface lwbc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lwbc_pkg::CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> sv/lru_writeback_block_cache_core.sv
// Results: a read/write hit or fill word comes after the command is taken and all slots are
// scanned, the replaced block of a full cache after the fill, then one word per further eviction.
// Flush and close scan all slots and wait on stalls on the output; trim gives one word per eviction and a done word.
// Throughput: one command at a time, ready only when idle; a command is held longer by each
// eviction and by any stalls on the output.
// Reset: rst_ni low clears all slots, the occupancy and sets max_blocks to 16.
module lru_writeback_block_cache_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  lwbc_in_if.sink  in_i,
  lwbc_cfg_if.sink cfg_i,
  lwbc_out_if.source out_o
);
  import lwbc_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  maxb_q, occ_q, lim;
  logic [2:0]        cmd_q;
  logic [FILE_W-1:0] f_q, done_file_q;
  logic [TAG_W-1:0]  tag_q;

  logic [SLOTS-1:0]  valid_q, dirty_q;
  logic [AGE_W-1:0]  age_q  [SLOTS];
  logic [FILE_W-1:0] file_q [SLOTS];
  logic [TAG_W-1:0]  tagm_q [SLOTS];

  logic [SLOT_W-1:0] s_q, hsl_q, fsl_q, lsl_q;
  logic              hit_q, free_q, lfound_q, ldirty_q;
  logic [AGE_W-1:0]  hage_q, lage_q;
  logic [FILE_W-1:0] lfile_q;
  logic [TAG_W-1:0]  ltag_q;

  logic              ov_q, olast_q;
  logic [2:0]        okind_q;
  logic [FILE_W-1:0] ofile_q;
  logic [TAG_W-1:0]  otag_q;
  logic [SLOT_W-1:0] oslot_q;

  logic              emit, e_last, step, s_end, cur_v, cur_fm, cur_tm, occ_over;
  logic              fill_over, ev_over;
  kind_e             e_kind;
  logic [FILE_W-1:0] e_file;
  logic [TAG_W-1:0]  e_tag;
  logic [SLOT_W-1:0] e_slot;

  always_comb begin
    lim = maxb_q;
    if (maxb_q == '0) lim = CNT_W'(1);
    if (maxb_q > CNT_W'(SLOTS)) lim = CNT_W'(SLOTS);
  end

  assign s_end     = (s_q == SLOT_W'(SLOTS - 1));
  assign cur_v     = valid_q[s_q];
  assign cur_fm    = cur_v && (file_q[s_q] == f_q);
  assign cur_tm    = cur_fm && (tagm_q[s_q] == tag_q);
  assign occ_over  = occ_q > lim;
  assign fill_over = ({1'b0, occ_q} + 6'd1) > {1'b0, lim};
  assign ev_over   = ({1'b0, occ_q} - 6'd1) > {1'b0, lim};

  // result word selection
  always_comb begin
    emit   = 1'b0;
    e_kind = KIND_DONE;
    e_file = f_q;
    e_tag  = tag_q;
    e_slot = '0;
    e_last = 1'b0;
    case (state_q)
      ST_ACC_RES: begin
        emit = 1'b1;
        if (hit_q) begin
          e_kind = KIND_HIT;
          e_slot = hsl_q;
          e_last = 1'b1;
        end else if (free_q) begin
          e_kind = KIND_FILL;
          e_slot = fsl_q;
          e_last = !fill_over;
        end else begin
          e_kind = KIND_FILL;
          e_slot = lsl_q;
        end
      end
      ST_ACC_OLD, ST_EV_EMIT: begin
        emit   = 1'b1;
        e_kind = ldirty_q ? KIND_WB : KIND_DROP;
        e_file = lfile_q;
        e_tag  = ltag_q;
        e_slot = lsl_q;
        if (state_q == ST_ACC_OLD) e_last = !occ_over;
        else e_last = (cmd_q != CMD_TRIM) && !ev_over;
      end
      ST_FLUSH, ST_CLOSE: begin
        emit   = cur_fm && dirty_q[s_q];
        e_kind = KIND_WB;
        e_tag  = tagm_q[s_q];
        e_slot = s_q;
      end
      ST_DONE: begin
        emit   = 1'b1;
        e_kind = KIND_DONE;
        e_file = done_file_q;
        e_tag  = '0;
        e_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  assign step = !emit || !ov_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_i.valid) begin
        case (in_i.cmd)
          CMD_READ, CMD_WRITE: state_d = ST_SCAN;
          CMD_FLUSH:           state_d = ST_FLUSH;
          CMD_CLOSE:           state_d = ST_CLOSE;
          CMD_TRIM:            state_d = occ_over ? ST_EV_SCAN : ST_DONE;
          default:             state_d = ST_DONE;
        endcase
      end
      ST_SCAN:    if (s_end) state_d = ST_ACC_RES;
      ST_ACC_RES: if (step) begin
        if (hit_q) state_d = ST_IDLE;
        else if (free_q) state_d = fill_over ? ST_EV_SCAN : ST_IDLE;
        else state_d = ST_ACC_OLD;
      end
      ST_ACC_OLD: if (step) state_d = occ_over ? ST_EV_SCAN : ST_IDLE;
      ST_EV_SCAN: if (s_end) state_d = ST_EV_EMIT;
      ST_EV_EMIT: if (step) begin
        if (ev_over) state_d = ST_EV_SCAN;
        else state_d = (cmd_q == CMD_TRIM) ? ST_DONE : ST_IDLE;
      end
      ST_FLUSH, ST_CLOSE: if (step && s_end) state_d = ST_DONE;
      ST_DONE:    if (step) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      maxb_q   <= CNT_W'(SLOTS);
      occ_q    <= '0;
      valid_q  <= '0;
      dirty_q  <= '0;
      age_q    <= '{default: '0};
      ov_q     <= 1'b0;
      s_q      <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      lfound_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) maxb_q <= cfg_i.data;
      if (emit && step) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          s_q      <= '0;
          hit_q    <= 1'b0;
          free_q   <= 1'b0;
          lfound_q <= 1'b0;
        end
        ST_SCAN, ST_EV_SCAN: begin
          s_q <= s_q + SLOT_W'(1);
          if (state_q == ST_SCAN) begin
            if (cur_tm && !hit_q) hit_q <= 1'b1;
            if (!cur_v && !free_q) free_q <= 1'b1;
          end
          if (cur_v && (!lfound_q || age_q[s_q] > lage_q)) lfound_q <= 1'b1;
        end
        ST_ACC_RES: if (step) begin
          if (hit_q) begin
            for (int t = 0; t < SLOTS; t++)
              if (valid_q[t] && age_q[t] < hage_q) age_q[t] <= age_q[t] + AGE_W'(1);
            age_q[hsl_q] <= '0;
            if (cmd_q == CMD_WRITE) dirty_q[hsl_q] <= 1'b1;
          end else begin
            for (int t = 0; t < SLOTS; t++)
              if (valid_q[t]) age_q[t] <= age_q[t] + AGE_W'(1);
            if (free_q) begin
              age_q[fsl_q]   <= '0;
              valid_q[fsl_q] <= 1'b1;
              dirty_q[fsl_q] <= (cmd_q == CMD_WRITE);
              occ_q          <= occ_q + CNT_W'(1);
            end else begin
              age_q[lsl_q]   <= '0;
              dirty_q[lsl_q] <= (cmd_q == CMD_WRITE);
            end
          end
          s_q      <= '0;
          lfound_q <= 1'b0;
        end
        ST_ACC_OLD: begin
          s_q      <= '0;
          lfound_q <= 1'b0;
        end
        ST_EV_EMIT: if (step) begin
          valid_q[lsl_q] <= 1'b0;
          dirty_q[lsl_q] <= 1'b0;
          age_q[lsl_q]   <= '0;
          occ_q          <= occ_q - CNT_W'(1);
          s_q            <= '0;
          lfound_q       <= 1'b0;
        end
        ST_FLUSH: if (step) begin
          s_q <= s_q + SLOT_W'(1);
          if (cur_fm) dirty_q[s_q] <= 1'b0;
        end
        ST_CLOSE: if (step) begin
          s_q <= s_q + SLOT_W'(1);
          if (cur_fm) begin
            for (int t = 0; t < SLOTS; t++)
              if (valid_q[t] && age_q[t] > age_q[s_q]) age_q[t] <= age_q[t] - AGE_W'(1);
            valid_q[s_q] <= 1'b0;
            dirty_q[s_q] <= 1'b0;
            age_q[s_q]   <= '0;
            occ_q        <= occ_q - CNT_W'(1);
          end
        end
        default: s_q <= s_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      cmd_q       <= in_i.cmd;
      f_q         <= in_i.file_id;
      tag_q       <= in_i.byte_offset[OFF_W-1:OFS_W];
      done_file_q <= (in_i.cmd == CMD_FLUSH || in_i.cmd == CMD_CLOSE) ? in_i.file_id : '0;
    end
    if (state_q == ST_SCAN) begin
      if (cur_tm && !hit_q) begin
        hsl_q  <= s_q;
        hage_q <= age_q[s_q];
      end
      if (!cur_v && !free_q) fsl_q <= s_q;
    end
    if ((state_q == ST_SCAN || state_q == ST_EV_SCAN) && cur_v
        && (!lfound_q || age_q[s_q] > lage_q)) begin
      lsl_q    <= s_q;
      lage_q   <= age_q[s_q];
      lfile_q  <= file_q[s_q];
      ltag_q   <= tagm_q[s_q];
      ldirty_q <= dirty_q[s_q];
    end
    if (state_q == ST_ACC_RES && step && !hit_q) begin
      file_q[free_q ? fsl_q : lsl_q] <= f_q;
      tagm_q[free_q ? fsl_q : lsl_q] <= tag_q;
    end
    if (emit && step) begin
      okind_q <= e_kind;
      ofile_q <= e_file;
      otag_q  <= e_tag;
      oslot_q <= e_slot;
      olast_q <= e_last;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.kind       = okind_q;
  assign out_o.out_file   = ofile_q;
  assign out_o.block_base = {otag_q, OFS_W'(0)};
  assign out_o.slot       = 4'(oslot_q);
  assign out_o.last       = olast_q;

  `include "lru_writeback_block_cache_core_macros.svh"

  `LWBC_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= CNT_W'(SLOTS), "occupancy beyond slot count")
  `LWBC_ASSERT_NEXT(a_busy_after_take, in_i.valid && in_i.ready, !in_i.ready, "ready after take")
  `LWBC_ASSERT_NOW(a_occ_matches, state_q == ST_IDLE, $countones(valid_q) == int'(occ_q), "occupancy mismatch")

endmodule

>>> test/lru_writeback_block_cache_core_tb.sv
`timescale 1ns / 100ps

module lru_writeback_block_cache_core_tb;
  import lwbc_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  file;
    logic [39:0] base;
    logic [3:0]  slot;
    logic        last;
  } blk_evt_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  file;
    logic [39:0] offset;
    logic        chk;
    blk_evt_t    want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lwbc_in_if  in_bus ();
  lwbc_out_if out_bus ();
  lwbc_cfg_if cfg_bus ();

  lru_writeback_block_cache_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .cfg_i  (cfg_bus.sink),
    .out_o  (out_bus.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow cache state
  logic        sh_valid [SLOTS];
  logic [7:0]  sh_file  [SLOTS];
  logic [39:0] sh_base  [SLOTS];
  logic        sh_dirty [SLOTS];
  int unsigned sh_age   [SLOTS];
  int unsigned sh_count;
  logic [4:0]  sh_limit;

  blk_evt_t  pending_evts[$];
  stim_row_t dir_chk_q[$];
  int        n_mismatch;
  int        n_words_out;
  int        n_words_in;
  int        idle_cycles;
  bit        hold_rx;
  bit        rx_pattern_on;

  function automatic int unsigned eff_limit();
    if (sh_limit == 0) return 1;
    if (sh_limit > SLOTS) return SLOTS;
    return sh_limit;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int s = 0; s < SLOTS; s++)
      if (sh_valid[s] && (best < 0 || sh_age[s] > sh_age[best])) best = s;
    return best;
  endfunction

  function automatic void push_evt(logic [2:0] k, logic [7:0] f, logic [39:0] b, int s);
    blk_evt_t e;
    e.kind = k;
    e.file = f;
    e.base = b;
    e.slot = 4'(s);
    e.last = 1'b0;
    pending_evts.push_back(e);
  endfunction

  function automatic void drop_oldest();
    int v;
    v = oldest_slot();
    if (v < 0) return;
    push_evt(sh_dirty[v] ? KIND_WB : KIND_DROP, sh_file[v], sh_base[v], v);
    sh_valid[v] = 1'b0;
    sh_dirty[v] = 1'b0;
    sh_age[v] = 0;
    if (sh_count > 0) sh_count--;
  endfunction

  function automatic void predict_cache(logic [2:0] cmd, logic [7:0] f, logic [39:0] off);
    logic [39:0] b;
    int          tgt;
    int          v;
    int unsigned a;
    int          n0;
    blk_evt_t    e;
    n0 = pending_evts.size();
    b = {off[39:12], 12'd0};
    tgt = -1;
    if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      for (int s = 0; s < SLOTS; s++)
        if (tgt < 0 && sh_valid[s] && sh_file[s] == f && sh_base[s] == b) tgt = s;
      if (tgt >= 0) begin
        for (int t = 0; t < SLOTS; t++)
          if (sh_valid[t] && sh_age[t] < sh_age[tgt]) sh_age[t]++;
        sh_age[tgt] = 0;
        if (cmd == CMD_WRITE) sh_dirty[tgt] = 1'b1;
        push_evt(KIND_HIT, f, b, tgt);
      end else begin
        for (int s = 0; s < SLOTS; s++)
          if (tgt < 0 && !sh_valid[s]) tgt = s;
        if (tgt < 0) begin
          v = oldest_slot();
          push_evt(KIND_FILL, f, b, v);
          push_evt(sh_dirty[v] ? KIND_WB : KIND_DROP, sh_file[v], sh_base[v], v);
          sh_valid[v] = 1'b0;
          tgt = v;
        end else begin
          push_evt(KIND_FILL, f, b, tgt);
          sh_count++;
        end
        for (int s = 0; s < SLOTS; s++)
          if (sh_valid[s]) sh_age[s]++;
        sh_valid[tgt] = 1'b1;
        sh_file[tgt] = f;
        sh_base[tgt] = b;
        sh_dirty[tgt] = (cmd == CMD_WRITE);
        sh_age[tgt] = 0;
        while (sh_count > eff_limit()) drop_oldest();
      end
    end else if (cmd == CMD_FLUSH) begin
      for (int s = 0; s < SLOTS; s++)
        if (sh_valid[s] && sh_file[s] == f && sh_dirty[s]) begin
          push_evt(KIND_WB, f, sh_base[s], s);
          sh_dirty[s] = 1'b0;
        end
      push_evt(KIND_DONE, f, '0, 0);
    end else if (cmd == CMD_CLOSE) begin
      for (int s = 0; s < SLOTS; s++)
        if (sh_valid[s] && sh_file[s] == f) begin
          a = sh_age[s];
          if (sh_dirty[s]) push_evt(KIND_WB, f, sh_base[s], s);
          sh_valid[s] = 1'b0;
          sh_dirty[s] = 1'b0;
          sh_age[s] = 0;
          if (sh_count > 0) sh_count--;
          for (int t = 0; t < SLOTS; t++)
            if (sh_valid[t] && sh_age[t] > a) sh_age[t]--;
        end
      push_evt(KIND_DONE, f, '0, 0);
    end else if (cmd == CMD_TRIM) begin
      while (sh_count > eff_limit()) drop_oldest();
      push_evt(KIND_DONE, '0, '0, 0);
    end else begin
      push_evt(KIND_DONE, '0, '0, 0);
    end
    if (pending_evts.size() > n0) begin
      e = pending_evts[$];
      e.last = 1'b1;
      pending_evts[pending_evts.size()-1] = e;
    end
  endfunction

  // sampling of accepted words
  always @(posedge clk_i) begin
    blk_evt_t  got;
    blk_evt_t  want;
    stim_row_t dir_row;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        n_words_in++;
        predict_cache(in_bus.cmd, in_bus.file_id, in_bus.byte_offset);
        if (dir_chk_q.size() != 0) begin
          dir_row = dir_chk_q.pop_front();
          if (dir_row.chk && pending_evts[$] !== dir_row.want) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("table row: want %p model %p",
                                           dir_row.want, pending_evts[$]);
          end
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        n_words_out++;
        got = '{out_bus.kind, out_bus.out_file, out_bus.block_base, out_bus.slot,
                out_bus.last};
        if (pending_evts.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected word: %p", got);
        end else begin
          want = pending_evts.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("mismatch: want %p got %p", want, got);
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_rx) out_bus.ready <= 1'b0;
    else if (!rx_pattern_on) out_bus.ready <= 1'b1;
    else out_bus.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_word(logic [2:0] cmd, logic [7:0] f, logic [39:0] off);
    in_bus.valid <= 1'b1;
    in_bus.cmd <= cmd;
    in_bus.file_id <= f;
    in_bus.byte_offset <= off;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic gap_after_burst(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_bus.valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
    burst_left = $urandom_range(0, 12);
  endtask

  task automatic drain_all();
    in_bus.valid <= 1'b0;
    while (pending_evts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [4:0] v);
    drain_all();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    sh_limit = v;
  endtask

  function automatic logic [39:0] rand_off(bit hot);
    if (hot) return {28'($urandom_range(0, 5)), 12'($urandom)};
    return {8'($urandom), $urandom};
  endfunction

  stim_row_t directed_rows[$];

  function automatic stim_row_t row(logic [2:0] c, logic [7:0] f, logic [39:0] o, bit chk,
                                    logic [2:0] k, logic [7:0] wf, logic [39:0] wb,
                                    logic [3:0] ws);
    stim_row_t r;
    r.cmd = c;
    r.file = f;
    r.offset = o;
    r.chk = chk;
    r.want = '{k, wf, wb, ws, 1'b1};
    return r;
  endfunction

  initial begin
    int burst_left;
    int phase_items;
    logic [2:0]  c;
    logic [7:0]  f;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_READ;
    in_bus.file_id = '0;
    in_bus.byte_offset = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    out_bus.ready = 1'b1;
    hold_rx = 1'b0;
    rx_pattern_on = 1'b0;
    n_mismatch = 0;
    n_words_out = 0;
    n_words_in = 0;
    idle_cycles = 0;
    sh_limit = 5'd16;
    sh_count = 0;
    for (int s = 0; s < SLOTS; s++) begin
      sh_valid[s] = 1'b0;
      sh_file[s] = '0;
      sh_base[s] = '0;
      sh_dirty[s] = 1'b0;
      sh_age[s] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cache, extremes, every command, unknown codes
    directed_rows = '{
      row(CMD_TRIM,  8'h00, '0, 1, KIND_DONE, 8'h00, '0, 0),
      row(CMD_FLUSH, 8'hff, '0, 1, KIND_DONE, 8'hff, '0, 0),
      row(CMD_CLOSE, 8'h00, '0, 1, KIND_DONE, 8'h00, '0, 0),
      row(CMD_READ,  8'h00, '0, 1, KIND_FILL, 8'h00, '0, 0),
      row(CMD_WRITE, 8'hff, '1, 1, KIND_FILL, 8'hff, 40'hff_ffff_f000, 1),
      row(CMD_READ,  8'h00, 40'hfff, 1, KIND_HIT, 8'h00, '0, 0),
      row(CMD_WRITE, 8'h00, 40'h1, 0, '0, '0, '0, 0),
      row(CMD_FLUSH, 8'h00, '0, 0, '0, '0, '0, 0),
      row(CMD_FLUSH, 8'h00, '0, 0, '0, '0, '0, 0),
      row(3'd5, 8'h12, 40'h5, 1, KIND_DONE, 8'h00, '0, 0),
      row(3'd7, 8'hff, '1, 1, KIND_DONE, 8'h00, '0, 0),
      row(3'd6, 8'h01, '0, 1, KIND_DONE, 8'h00, '0, 0),
      row(CMD_CLOSE, 8'hff, '0, 0, '0, '0, '0, 0),
      row(CMD_WRITE, 8'h55, 40'haa_aaaa_aaaa, 0, '0, '0, '0, 0),
      row(CMD_READ,  8'haa, 40'h55_5555_5555, 0, '0, '0, '0, 0)
    };
    foreach (directed_rows[i]) begin
      dir_chk_q.push_back(directed_rows[i]);
      send_word(directed_rows[i].cmd, directed_rows[i].file, directed_rows[i].offset);
    end
    // fill past 16 slots to force replacement
    for (int i = 0; i < 18; i++) send_word(CMD_WRITE, 8'(i[0]), 40'(i) << 12);
    set_limit(5'd1);
    send_word(CMD_TRIM, 8'h00, '0);
    send_word(CMD_READ, 8'h03, 40'h3000);

    // random phases over several limits, extremes included
    rx_pattern_on = 1'b1;
    burst_left = 4;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_limit(5'd16);
        1: set_limit(5'd4);
        2: set_limit(5'd0);
        3: set_limit(5'd31);
        4: set_limit(5'd2);
        5: set_limit(5'd9);
        default: set_limit(5'd16);
      endcase
      phase_items = (p == 1 || p == 4) ? 20 : 35;
      if (p == 3) rx_pattern_on = 1'b0;
      else rx_pattern_on = 1'b1;
      for (int i = 0; i < phase_items; i++) begin
        case ($urandom_range(0, 19))
          0, 1:    c = CMD_FLUSH;
          2:       c = CMD_CLOSE;
          3:       c = CMD_TRIM;
          4:       c = 3'($urandom_range(5, 7));
          5, 6, 7, 8, 9, 10: c = CMD_WRITE;
          default: c = CMD_READ;
        endcase
        f = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        if (p == 2 && i == 10) begin
          fork
            begin
              hold_rx = 1'b1;
              repeat (300) @(posedge clk_i);
              hold_rx = 1'b0;
            end
          join_none
        end
        send_word(c, f, rand_off($urandom_range(0, 5) != 0));
        gap_after_burst(burst_left);
      end
      if (p == 5) drain_all();
    end
    drain_all();
    $display("covered %0d input words and %0d result words over seven limit settings",
             n_words_in, n_words_out);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/lwbc_pkg.sv
sv/lwbc_in_if.sv
sv/lwbc_out_if.sv
sv/lwbc_cfg_if.sv
sv/lru_writeback_block_cache_core.sv
test/lru_writeback_block_cache_core_tb.sv
